### sv/narma_pkg.sv
// shared constants and types for the narma10 series generator
`default_nettype none

package narma_pkg;

  localparam int ORDER      = 10;
  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 32;
  localparam int FRAC       = 24;
  localparam int WSUM_W     = 36;
  localparam int SEEN_W     = 4;

  // coefficients rounded to nearest at FRAC fraction bits
  localparam logic signed [23:0] C03  = 24'sd5033165;
  localparam logic signed [20:0] C005 = 21'sd838861;
  localparam logic signed [33:0] C01  = 34'sd1677722;

  localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(ORDER - 1);

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic sum;
    logic finish;
  } narma_cmd_t;

endpackage

`default_nettype wire

### sv/narma10_series_generator_unit.sv
// top level of the narma10 series generator
//
// input channel: sample (signed Q1.15) and restart, with sample_valid and
// sample_stall. a beat is taken when sample_valid is high and sample_stall
// is low. restart clears all history, so that beat returns zero.
// output channel: series_value (signed Q7.24) and saturated, with
// series_valid and series_stall. each input beat yields exactly one output
// beat carrying y(t); saturated flags that y(t+1), formed in the same step,
// clipped at the 32-bit limits.
// each sample passes through the steps load, mul1, mul2, sum and finish;
// a new sample is taken only once the last one has left the finish step,
// held back by the multiply chain that scales y and then multiplies by the
// 36-bit window sum in two halves. the finished result sits in an output
// register, so the next sample is taken while it waits. if the receiver
// stalls, the result holds and the following item waits in its last step
// until the register frees. reset (rst, synchronous) clears histories,
// window sum, counter and the output valid.
`default_nettype none

module narma10_series_generator_unit
  import narma_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        sample_valid,
  output logic                       sample_stall,
  input  wire signed [SAMPLE_W-1:0]  sample,
  input  wire                        restart,
  output logic                       series_valid,
  input  wire                        series_stall,
  output logic signed [VALUE_W-1:0]  series_value,
  output logic                       saturated
);

  narma_cmd_t cmd;

  narma_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .series_valid (series_valid),
    .series_stall (series_stall),
    .cmd          (cmd)
  );

  narma_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample       (sample),
    .restart      (restart),
    .series_value (series_value),
    .saturated    (saturated)
  );

endmodule

`default_nettype wire

### sv/narma_ctrl.sv
// sequencing state machine and output valid for the narma10 generator
`default_nettype none

module narma_ctrl
  import narma_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        sample_valid,
  output logic       sample_stall,
  output logic       series_valid,
  input  wire        series_stall,
  output narma_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign sample_stall = (state != S_IDLE);
  assign out_free     = !series_valid || !series_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold here until the output register can take the beat
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      series_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        series_valid <= 1'b1;
      end else if (!series_stall) begin
        series_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### sv/narma_datapath.sv
// histories, window sum and fixed-point arithmetic for the narma10 generator
`default_nettype none

module narma_datapath
  import narma_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  narma_cmd_t                 cmd,
  input  wire signed [SAMPLE_W-1:0]  sample,
  input  wire                        restart,
  output logic signed [VALUE_W-1:0]  series_value,
  output logic                       saturated
);

  logic signed [VALUE_W-1:0]  out_hist [ORDER];
  logic signed [SAMPLE_W-1:0] samp_hist [ORDER-1];
  logic signed [WSUM_W-1:0]   wsum;
  logic signed [VALUE_W-1:0]  next_value;
  logic [SEEN_W-1:0]          seen;

  logic signed [VALUE_W-1:0]  y_reg;
  logic signed [SAMPLE_W-1:0] u_cur;
  logic signed [SAMPLE_W-1:0] u_old;
  logic                       active;

  logic signed [55:0] prod_t1;
  logic signed [52:0] prod_a;
  logic signed [31:0] prod_p;
  logic signed [47:0] pp_lo;
  logic signed [46:0] pp_hi;
  logic signed [33:0] t13;
  logic signed [64:0] full;

  // load step
  logic signed [VALUE_W-1:0] y_now;
  logic signed [VALUE_W-1:0] old_last;
  logic signed [WSUM_W-1:0]  wsum_base;
  logic [SEEN_W-1:0]         seen_base;

  assign y_now     = restart ? '0 : next_value;
  assign old_last  = restart ? '0 : out_hist[ORDER-1];
  assign wsum_base = restart ? '0 : wsum;
  assign seen_base = restart ? '0 : seen;

  // multiply steps
  logic signed [28:0] a_val;
  logic signed [31:0] t1;
  logic signed [33:0] p3;
  logic signed [26:0] t3;

  assign a_val = prod_a[52:24];
  assign t1    = prod_t1[55:24];
  assign p3    = $signed({{2{prod_p[31]}}, prod_p}) + $signed({prod_p[31], prod_p, 1'b0});
  assign t3    = p3[33:7];

  // final add and clip
  logic signed [40:0] t2;
  logic signed [41:0] tot;
  logic               clip;
  logic signed [VALUE_W-1:0] tot_sat;

  assign t2   = full[64:24];
  assign tot  = $signed({t2[40], t2}) + $signed({{8{t13[33]}}, t13});
  assign clip = (tot[41:31] != {11{tot[41]}});

  always_comb begin
    if (!clip) begin
      tot_sat = tot[VALUE_W-1:0];
    end else if (tot[41]) begin
      tot_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      tot_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // model state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER; i++) out_hist[i] <= '0;
      for (int i = 0; i < ORDER-1; i++) samp_hist[i] <= '0;
      wsum       <= '0;
      next_value <= '0;
      seen       <= '0;
    end else begin
      if (cmd.load) begin
        wsum <= wsum_base + $signed({{(WSUM_W-VALUE_W){y_now[VALUE_W-1]}}, y_now})
                - $signed({{(WSUM_W-VALUE_W){old_last[VALUE_W-1]}}, old_last});
        out_hist[0]  <= y_now;
        samp_hist[0] <= sample;
        for (int i = 1; i < ORDER; i++) out_hist[i] <= restart ? '0 : out_hist[i-1];
        for (int i = 1; i < ORDER-1; i++) samp_hist[i] <= restart ? '0 : samp_hist[i-1];
        if (seen_base < SEEN_FULL) begin
          seen <= seen_base + SEEN_W'(1);
        end else begin
          seen <= seen_base;
        end
      end
      if (cmd.finish) begin
        next_value <= active ? tot_sat : '0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_reg  <= y_now;
      u_cur  <= sample;
      u_old  <= restart ? '0 : samp_hist[ORDER-2];
      active <= (seen_base >= SEEN_FULL);
    end
    if (cmd.mul1) begin
      prod_t1 <= C03 * y_reg;
      prod_a  <= C005 * y_reg;
      prod_p  <= u_cur * u_old;
    end
    if (cmd.mul2) begin
      // window sum split into two halves to keep each multiplier narrow
      pp_lo <= a_val * $signed({1'b0, wsum[17:0]});
      pp_hi <= a_val * $signed(wsum[WSUM_W-1:18]);
      t13   <= $signed({{2{t1[31]}}, t1}) + $signed({{7{t3[26]}}, t3}) + C01;
    end
    if (cmd.sum) begin
      full <= $signed({pp_hi, 18'd0}) + $signed({{17{pp_lo[47]}}, pp_lo});
    end
    if (cmd.finish) begin
      series_value <= y_reg;
      saturated    <= active && clip;
    end
  end

endmodule

`default_nettype wire

### sv/narma_checker.sv
// port-level checks for the narma10 series generator and their bind
`default_nettype none

module narma_checker
  import narma_pkg::*;
(
  input wire                       clk,
  input wire                       rst,
  input wire                       sample_valid,
  input wire                       sample_stall,
  input wire                       series_valid,
  input wire                       series_stall,
  input wire signed [VALUE_W-1:0]  series_value,
  input wire                       saturated
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pending;

  assign in_beat  = sample_valid && !sample_stall;
  assign out_beat = series_valid && !series_stall;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_beat) - 2'(out_beat);
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> sample_stall)
    else $error("input taken while a sample is still being worked");

  a_no_invented_beat: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> (pending != 2'd0))
    else $error("output beat with no pending input");

  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items outstanding");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (series_valid && series_stall) |=>
      (series_valid && $stable(series_value) && $stable(saturated)))
    else $error("stalled output beat changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !series_valid)
    else $error("output valid after reset");

endmodule

bind narma10_series_generator_unit narma_checker u_chk (.*);

`default_nettype wire

### tb/sv/tb_narma10_series_generator_unit.sv
// testbench for the narma10 series generator: directed table, random sequences, predictor check
`default_nettype none

module tb_narma10_series_generator_unit
  import narma_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 20;

  // coefficients rounded to nearest at FRAC fraction bits
  localparam longint K_03  = ((longint'(3) << FRAC) + 5) / 10;
  localparam longint K_005 = ((longint'(1) << FRAC) + 10) / 20;
  localparam longint K_01  = ((longint'(1) << FRAC) + 5) / 10;
  localparam int     U_SHIFT = 2 * (SAMPLE_W - 1) + 1 - FRAC;
  localparam longint VALUE_MAX = (longint'(1) << (VALUE_W - 1)) - 1;
  localparam longint VALUE_MIN = -(longint'(1) << (VALUE_W - 1));

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      sat;
  } series_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] u;
    logic                       rs;
    logic                       known;
    logic signed [VALUE_W-1:0]  y;
    logic                       sat;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       restart = 1'b0;
  logic                       series_valid;
  logic                       series_stall = 1'b0;
  logic signed [VALUE_W-1:0]  series_value;
  logic                       saturated;

  narma10_series_generator_unit uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .restart      (restart),
    .series_valid (series_valid),
    .series_stall (series_stall),
    .series_value (series_value),
    .saturated    (saturated)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic signed [VALUE_W-1:0]  hist_y [ORDER];
  logic signed [SAMPLE_W-1:0] hist_u [ORDER];
  longint                     y_window_sum = 0;
  logic signed [VALUE_W-1:0]  pending_y = '0;
  int                         warm_count = 0;

  series_beat_t expected_series [$];
  int           error_count = 0;
  int           beat_count = 0;
  int           gap_pct = 20;
  int           stall_pct = 20;
  int           stall_left = 0;

  // directed rows: warm-up and restart beats return zero, the rest use the predictor
  stim_row_t directed_rows [22] = '{
    '{16'sh8000, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh8000, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh7fff, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'shffff, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh0000, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh0001, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh5555, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'shaaaa, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh4000, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'shc000, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh8000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{16'sh7fff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{16'sh8000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{16'sh7fff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{16'shffff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{16'sh8000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{16'sh7fff, 1'b1, 1'b1, 32'sd0, 1'b0},
    '{16'sh1234, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'shedcb, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh0001, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh8000, 1'b0, 1'b1, 32'sd0, 1'b0},
    '{16'sh0000, 1'b1, 1'b1, 32'sd0, 1'b0}
  };

  // returns y(t) and advances the series by one sample
  function automatic series_beat_t narma_advance(input logic signed [SAMPLE_W-1:0] u,
                                                 input logic rs);
    series_beat_t beat;
    longint       yl, t1, a, t2, t3, total;
    int           i;
    beat.sat = 1'b0;
    if (rs) begin
      for (i = 0; i < ORDER; i++) begin
        hist_y[i] = '0;
        hist_u[i] = '0;
      end
      y_window_sum = 0;
      pending_y = '0;
      warm_count = 0;
    end
    beat.value = pending_y;
    y_window_sum += longint'(pending_y) - longint'(hist_y[ORDER-1]);
    for (i = ORDER - 1; i > 0; i--) begin
      hist_y[i] = hist_y[i-1];
      hist_u[i] = hist_u[i-1];
    end
    hist_y[0] = pending_y;
    hist_u[0] = u;
    if (warm_count >= ORDER - 1) begin
      yl = longint'(pending_y);
      t1 = (K_03 * yl) >>> FRAC;
      a = (K_005 * yl) >>> FRAC;
      t2 = (a * y_window_sum) >>> FRAC;
      t3 = (longint'(3) * (longint'(u) * longint'(hist_u[ORDER-1]))) >>> U_SHIFT;
      total = t1 + t2 + t3 + K_01;
      if (total > VALUE_MAX) begin
        total = VALUE_MAX;
        beat.sat = 1'b1;
      end else if (total < VALUE_MIN) begin
        total = VALUE_MIN;
        beat.sat = 1'b1;
      end
      pending_y = total[VALUE_W-1:0];
    end else begin
      pending_y = '0;
      warm_count++;
    end
    return beat;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch on beat %0d: %s", $realtime, beat_count, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(99) >= gap_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int mode);
    case (mode)
      0: return SAMPLE_W'($urandom_range(16384));
      1: return SAMPLE_W'($urandom);
      default: begin
        case ($urandom_range(4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'shffff;
          3: return 16'sh0000;
          default: return SAMPLE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] u, input logic rs,
                             input logic known, input logic signed [VALUE_W-1:0] known_y,
                             input logic known_sat);
    series_beat_t predicted;
    series_beat_t typed;
    sample <= u;
    restart <= rs;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    predicted = narma_advance(u, rs);
    typed.value = known_y;
    typed.sat = known_sat;
    expected_series.push_back(known ? typed : predicted);
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      sample_valid <= 1'b0;
      sample <= SAMPLE_W'($urandom);
      restart <= 1'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    sample_valid <= 1'b0;
    while (expected_series.size() != 0) @(posedge clk);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      series_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      series_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      series_stall <= 1'b1;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
    end else begin
      series_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_beats
    series_beat_t want;
    if (!rst && series_valid && !series_stall) begin
      if (expected_series.size() == 0) begin
        note_mismatch($sformatf("unexpected beat, value %0d", series_value));
      end else begin
        want = expected_series.pop_front();
        if (series_value !== want.value)
          note_mismatch($sformatf("series_value %0d, want %0d", series_value, want.value));
        if (saturated !== want.sat)
          note_mismatch($sformatf("saturated %0b, want %0b", saturated, want.sat));
      end
      beat_count++;
    end
  end

  initial begin : stimulus
    int                         sent, seq_len, mode, k;
    logic signed [SAMPLE_W-1:0] u;
    logic                       rs;
    foreach (hist_y[i]) begin
      hist_y[i] = '0;
      hist_u[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].u, directed_rows[i].rs, directed_rows[i].known,
                  directed_rows[i].y, directed_rows[i].sat);
      idle_input(pick_gap());
    end
    wait_for_drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seq_len = $urandom_range(60, 12);
      mode = $urandom_range(2);
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 25;
        default: gap_pct = 60;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 20;
        default: stall_pct = 50;
      endcase
      for (k = 0; k < seq_len; k++) begin
        u = draw_sample(mode);
        // most sequences open with a restart, a stray one now and then
        rs = (k == 0 && $urandom_range(5) != 0) || ($urandom_range(49) == 0);
        send_sample(u, rs, 1'b0, '0, 1'b0);
        sent++;
        idle_input(pick_gap());
      end
      if ($urandom_range(5) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
